[rtl/fcc_pkg.sv]
// ----------------------------------------------------------------------------
// fcc_pkg
// Types, character codes and pattern helpers shared by the complexity counter.
// ----------------------------------------------------------------------------
package fcc_pkg;

  typedef struct packed {
    logic       body;
    logic       emit;
    logic [3:0] lines;
    logic [7:0] code;
  } fcc_cmd_t;

  typedef struct packed {
    logic hit;
    logic case_hit;
  } fcc_match_t;

  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_NL     = 8'h0A;
  localparam logic [7:0] CH_SEMI   = 8'h3B;
  localparam logic [7:0] CH_EQ     = 8'h3D;
  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_RBRACE = 8'h7D;

  localparam logic signed [15:0] DEPTH_MAX = 16'sh7FFF;
  localparam logic signed [15:0] DEPTH_MIN = -16'sh8000;

  localparam logic [2:0]  STRUCT_LEN  = 3'd6;
  localparam logic [47:0] WORD_STRUCT = "struct";

  localparam logic [23:0] PAT_IF_SP    = "if ";
  localparam logic [23:0] PAT_IF_PAR   = "if(";
  localparam logic [31:0] PAT_FOR_SP   = "for ";
  localparam logic [31:0] PAT_FOR_PAR  = "for(";
  localparam logic [47:0] PAT_WHILE_SP = "while ";
  localparam logic [47:0] PAT_WHILE_PR = "while(";
  localparam logic [39:0] PAT_CASE_SP  = "case ";
  localparam logic [15:0] PAT_AND      = "&&";
  localparam logic [15:0] PAT_OR       = "||";

  function automatic logic [7:0] struct_char(input logic [2:0] pos);
    logic [7:0] c;
    case (pos)
      3'd0:    c = WORD_STRUCT[47:40];
      3'd1:    c = WORD_STRUCT[39:32];
      3'd2:    c = WORD_STRUCT[31:24];
      3'd3:    c = WORD_STRUCT[23:16];
      3'd4:    c = WORD_STRUCT[15:8];
      3'd5:    c = WORD_STRUCT[7:0];
      default: c = CH_NUL;
    endcase
    return c;
  endfunction

  // newest byte in the lowest bits
  function automatic fcc_match_t match_tail(input logic [47:0] win);
    fcc_match_t m;
    m.case_hit = (win[39:0] == PAT_CASE_SP);
    m.hit = (win[23:0] == PAT_IF_SP) || (win[23:0] == PAT_IF_PAR) ||
            (win[31:0] == PAT_FOR_SP) || (win[31:0] == PAT_FOR_PAR) ||
            (win[47:0] == PAT_WHILE_SP) || (win[47:0] == PAT_WHILE_PR) ||
            m.case_hit || (win[15:0] == PAT_AND) || (win[15:0] == PAT_OR);
    return m;
  endfunction

endpackage

[rtl/function_complexity_counter.sv]
// ----------------------------------------------------------------------------
// function_complexity_counter
// Per-function line, cyclomatic and case-label counts from a C byte stream.
// ----------------------------------------------------------------------------
// One source byte is taken per cycle while the queue has room. The front
// stage tracks brace depth and the struct/initialiser skip flag and passes
// a command through a two-entry queue to the back stage, which updates the
// line window and the saturating counters as it takes each command. The
// back stage writes a result into the output register when it takes the
// command of the closing brace; an untaken result can hold the back stage.
// The back stage stalls only when a new result finds the previous one still
// untaken, and the front stalls only once the queue is full.
module function_complexity_counter #(
  parameter int LINE_BUFFER = 256
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,   // code_byte[7:0], raw_newlines[11:8], zero pad
  input  logic [0:0]  s_tuser,   // in_quote[0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [47:0] m_tdata    // line_count[15:0], complexity[31:16], case_count[47:32]
);

  logic              f_valid, f_ready;
  fcc_pkg::fcc_cmd_t f_cmd;
  logic              q_valid, q_ready;
  fcc_pkg::fcc_cmd_t q_cmd;

  fcc_front u_front (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (s_tvalid),
    .in_ready     (s_tready),
    .code_byte    (s_tdata[7:0]),
    .in_quote     (s_tuser[0]),
    .raw_newlines (s_tdata[11:8]),
    .cmd_valid    (f_valid),
    .cmd          (f_cmd),
    .cmd_ready    (f_ready)
  );

  fcc_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (f_valid),
    .push_ready (f_ready),
    .push_cmd   (f_cmd),
    .pop_valid  (q_valid),
    .pop_ready  (q_ready),
    .pop_cmd    (q_cmd)
  );

  fcc_back #(
    .LINE_BUFFER (LINE_BUFFER)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .cmd_valid  (q_valid),
    .cmd_ready  (q_ready),
    .cmd        (q_cmd),
    .out_valid  (m_tvalid),
    .out_ready  (m_tready),
    .line_count (m_tdata[15:0]),
    .complexity (m_tdata[31:16]),
    .case_count (m_tdata[47:32])
  );

`ifndef NO_ASSERTIONS
  a_emit_shows: assert property (@(posedge clk) disable iff (rst)
    q_valid && q_ready && q_cmd.emit |=> m_tvalid)
    else $error("closing brace did not produce a result");

  a_full_has_work: assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> q_valid)
    else $error("input stalled with empty queue");

  a_cx_nonzero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[31:16] != 16'd0)
    else $error("complexity of zero emitted");

  a_reset_clear: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("result valid after reset");
`endif

endmodule

[rtl/fcc_front.sv]
// ----------------------------------------------------------------------------
// fcc_front
// Brace depth, struct matcher and skip flag; turns bytes with work into commands.
// ----------------------------------------------------------------------------
module fcc_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [7:0]        code_byte,
  input  logic              in_quote,
  input  logic [3:0]        raw_newlines,
  output logic              cmd_valid,
  output fcc_pkg::fcc_cmd_t cmd,
  input  logic              cmd_ready
);

  logic signed [15:0] depth, depth_next;
  logic               skip, skip_next;
  logic [2:0]         pos, pos_next;
  logic               in_func, in_func_next;
  logic               accept;
  logic               depth_zero, depth_pos;

  assign in_ready   = cmd_ready;
  assign accept     = in_valid && cmd_ready;
  assign depth_zero = (depth == 16'sd0);
  assign depth_pos  = !depth[15] && !depth_zero;

  always_comb begin
    skip_next    = skip;
    pos_next     = pos;
    depth_next   = depth;
    in_func_next = in_func;
    cmd.lines    = in_func ? raw_newlines : 4'd0;
    cmd.code     = code_byte;
    cmd.body     = 1'b0;
    cmd.emit     = 1'b0;
    if (!in_quote) begin
      if (depth_zero) begin
        if (pos < fcc_pkg::STRUCT_LEN && code_byte == fcc_pkg::struct_char(pos)) begin
          pos_next = pos + 3'd1;
          if (pos_next == fcc_pkg::STRUCT_LEN) skip_next = 1'b1;
        end else begin
          pos_next = 3'd0;
        end
        if (code_byte == fcc_pkg::CH_EQ) skip_next = 1'b1;
        if (code_byte == fcc_pkg::CH_SEMI) skip_next = 1'b0;
      end
      cmd.body = depth_pos && !skip_next;
      if (cmd.body) in_func_next = 1'b1;
      if (code_byte == fcc_pkg::CH_LBRACE) begin
        if (depth != fcc_pkg::DEPTH_MAX) depth_next = depth + 16'sd1;
      end else if (code_byte == fcc_pkg::CH_RBRACE) begin
        if (depth != fcc_pkg::DEPTH_MIN) depth_next = depth - 16'sd1;
        if (depth_next == 16'sd0 && !skip_next) begin
          cmd.emit     = 1'b1;
          in_func_next = 1'b0;
        end
      end
    end
    cmd_valid = in_valid && (cmd.body || cmd.emit || cmd.lines != 4'd0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      depth   <= 16'sd0;
      skip    <= 1'b0;
      pos     <= 3'd0;
      in_func <= 1'b0;
    end else if (accept) begin
      depth   <= depth_next;
      skip    <= skip_next;
      pos     <= pos_next;
      in_func <= in_func_next;
    end
  end

endmodule

[rtl/fcc_queue.sv]
// ----------------------------------------------------------------------------
// fcc_queue
// Two-entry command queue between the front and back parts.
// ----------------------------------------------------------------------------
module fcc_queue (
  input  logic              clk,
  input  logic              rst,
  input  logic              push_valid,
  output logic              push_ready,
  input  fcc_pkg::fcc_cmd_t push_cmd,
  output logic              pop_valid,
  input  logic              pop_ready,
  output fcc_pkg::fcc_cmd_t pop_cmd
);

  fcc_pkg::fcc_cmd_t slots [2];
  logic              wptr, rptr;
  logic [1:0]        count;
  logic              push, pop;

  assign push_ready = (count != 2'd2);
  assign pop_valid  = (count != 2'd0);
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;
  assign pop_cmd    = slots[rptr];

  always_ff @(posedge clk) begin
    if (push) slots[wptr] <= push_cmd;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= 1'b0;
      rptr  <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push) wptr <= !wptr;
      if (pop) rptr <= !rptr;
      case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

[rtl/fcc_back.sv]
// ----------------------------------------------------------------------------
// fcc_back
// Line window, pattern matching, saturating totals and the result register.
// ----------------------------------------------------------------------------
module fcc_back #(
  parameter int LINE_BUFFER = 256
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              cmd_valid,
  output logic              cmd_ready,
  input  fcc_pkg::fcc_cmd_t cmd,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [15:0]       line_count,
  output logic [15:0]       complexity,
  output logic [15:0]       case_count
);

  localparam int FW = $clog2(LINE_BUFFER + 1);
  localparam logic [FW-1:0] FILL_FULL = FW'(LINE_BUFFER);

  logic [FW-1:0] fill, fill_next;
  logic [47:0]   window, window_next;
  logic [15:0]   pend_cx, pend_cx_next;
  logic [7:0]    pend_cs, pend_cs_next;
  logic [15:0]   tot_cx, tot_cx_next;
  logic [15:0]   tot_cs, tot_cs_next;
  logic [15:0]   tot_ln, tot_ln_next;
  logic [16:0]   ln_sum, cx_sum, cs_sum;
  logic [15:0]   ln_sat;
  fcc_pkg::fcc_match_t m;
  logic          fire;

  assign cmd_ready = !cmd.emit || !out_valid || out_ready;
  assign fire      = cmd_valid && cmd_ready;

  always_comb begin
    fill_next    = fill;
    window_next  = window;
    pend_cx_next = pend_cx;
    pend_cs_next = pend_cs;
    tot_cx_next  = tot_cx;
    tot_cs_next  = tot_cs;
    m            = '0;
    ln_sum = {1'b0, tot_ln} + 17'(cmd.lines);
    ln_sat = ln_sum[16] ? 16'hFFFF : ln_sum[15:0];
    cx_sum = {1'b0, tot_cx} + {1'b0, pend_cx};
    cs_sum = {1'b0, tot_cs} + 17'(pend_cs);
    tot_ln_next = ln_sat;
    if (cmd.body) begin
      if (cmd.code != fcc_pkg::CH_NL) begin
        if (fill < FILL_FULL) begin
          if (cmd.code == fcc_pkg::CH_NUL) begin
            fill_next = FILL_FULL;
          end else begin
            window_next = {window[39:0], cmd.code};
            fill_next   = fill + FW'(1);
            m           = fcc_pkg::match_tail(window_next);
            if (m.hit && pend_cx != 16'hFFFF) pend_cx_next = pend_cx + 16'd1;
            if (m.case_hit && pend_cs != 8'hFF) pend_cs_next = pend_cs + 8'd1;
          end
        end
      end else begin
        tot_cx_next  = cx_sum[16] ? 16'hFFFF : cx_sum[15:0];
        tot_cs_next  = cs_sum[16] ? 16'hFFFF : cs_sum[15:0];
        pend_cx_next = 16'd0;
        pend_cs_next = 8'd0;
        fill_next    = '0;
        window_next  = '0;
      end
    end
    if (cmd.emit) begin
      tot_ln_next = 16'd0;
      tot_cx_next = 16'd1;
      tot_cs_next = 16'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill    <= '0;
      window  <= '0;
      pend_cx <= 16'd0;
      pend_cs <= 8'd0;
      tot_cx  <= 16'd1;
      tot_cs  <= 16'd0;
      tot_ln  <= 16'd0;
    end else if (fire) begin
      fill    <= fill_next;
      window  <= window_next;
      pend_cx <= pend_cx_next;
      pend_cs <= pend_cs_next;
      tot_cx  <= tot_cx_next;
      tot_cs  <= tot_cs_next;
      tot_ln  <= tot_ln_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (fire && cmd.emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && cmd.emit) begin
      line_count <= ln_sat;
      complexity <= tot_cx;
      case_count <= tot_cs;
    end
  end

endmodule
